/* src/mufl_pkg.sv */
`timescale 1ns / 1ps
package mufl_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0]  CRC_POLY      = 8'h8C;
  localparam logic [7:0]  CRC_INIT      = 8'h00;
  localparam logic [7:0]  FRAME_PAD     = 8'h00;
  localparam logic [7:0]  DEV_ADDR_RST  = 8'd1;
  localparam logic [15:0] TIMEOUT_RST   = 16'd200;

  localparam logic [3:0]  REPLY_BODY_LEN = 4'd9;
  localparam logic [3:0]  FRAME_CRC_IDX  = 4'd9;

  localparam int          CFG_IDX_W    = 2;
  localparam int          CFG_DATA_W   = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;

  typedef enum logic [1:0] {
    IN_SEND = 2'd0,
    IN_RX   = 2'd1,
    IN_TICK = 2'd2
  } in_kind_t;

  typedef enum logic [1:0] {
    RES_TX      = 2'd0,
    RES_REPLY   = 2'd1,
    RES_TIMEOUT = 2'd2
  } res_kind_t;

  // A send carries the eight frame bytes ahead of the pad byte, high byte first.
  // A reply carries {14'b0, crc_ok, match, feedback_one, feedback_two, temp, fault}.
  typedef struct packed {
    res_kind_t   kind;
    logic [63:0] data;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] din);
    logic [7:0] c;
    c = crc ^ din;
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* src/mufl_front.sv */
`timescale 1ns / 1ps
module mufl_front #(
  parameter int TIMER_WIDTH = mufl_pkg::TIMER_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mufl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mufl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_kind,
  input  logic [7:0]                      in_command_code,
  input  logic signed [15:0]              in_speed_value,
  input  logic [7:0]                      in_feedback_select_a,
  input  logic [7:0]                      in_feedback_select_b,
  input  logic [7:0]                      in_accel_time,
  input  logic [7:0]                      in_brake_code,
  input  logic                            in_expect_reply,
  input  logic [7:0]                      in_rx_byte,
  output logic                            job_valid,
  input  logic                            job_ready,
  output mufl_pkg::job_t                  job
);

  localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  logic [7:0]             dev_addr_r;
  logic [15:0]            timeout_r;
  logic                   waiting_r, waiting_nxt;
  logic [3:0]             count_r, count_nxt;
  logic [TIMER_WIDTH-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [7:0]             crc_r, crc_nxt;
  logic [7:0]             sent_cmd_r, sent_cmd_nxt;
  logic [7:0]             reply_store_r [9];
  logic                   store_we;
  logic                   accept;
  logic                   push;
  logic                   crc_ok;
  logic                   match;
  logic                   fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = job_ready;
  assign accept    = in_valid && in_ready;
  assign job_valid = accept && push;

  assign elapsed_inc = (elapsed_r == TIMER_MAX) ? elapsed_r : elapsed_r + TIMER_WIDTH'(1);
  assign fire = (CMP_W'(elapsed_inc) >= CMP_W'(timeout_r)) || (elapsed_inc == TIMER_MAX);
  assign crc_ok = (crc_r == in_rx_byte);
  assign match  = crc_ok && (reply_store_r[0] == dev_addr_r) && (reply_store_r[1] == sent_cmd_r);

  always_comb begin
    waiting_nxt  = waiting_r;
    count_nxt    = count_r;
    elapsed_nxt  = elapsed_r;
    crc_nxt      = crc_r;
    sent_cmd_nxt = sent_cmd_r;
    store_we     = 1'b0;
    push         = 1'b0;
    job.kind     = mufl_pkg::RES_TX;
    job.data     = '0;
    unique case (in_kind)
      mufl_pkg::IN_SEND: begin
        push        = 1'b1;
        job.kind    = mufl_pkg::RES_TX;
        job.data    = {dev_addr_r, in_command_code, in_speed_value, in_feedback_select_a,
                       in_feedback_select_b, in_accel_time, in_brake_code};
        waiting_nxt = in_expect_reply;
        count_nxt   = '0;
        elapsed_nxt = '0;
        crc_nxt     = mufl_pkg::CRC_INIT;
        if (in_expect_reply) begin
          sent_cmd_nxt = in_command_code;
        end
      end
      mufl_pkg::IN_RX: begin
        if (waiting_r) begin
          if (count_r < mufl_pkg::REPLY_BODY_LEN) begin
            store_we  = 1'b1;
            crc_nxt   = mufl_pkg::crc_feed(crc_r, in_rx_byte);
            count_nxt = count_r + 4'd1;
          end else begin
            push        = 1'b1;
            job.kind    = mufl_pkg::RES_REPLY;
            job.data    = {14'd0, crc_ok, match, reply_store_r[2], reply_store_r[3],
                           reply_store_r[4], reply_store_r[5], reply_store_r[7],
                           reply_store_r[8]};
            waiting_nxt = 1'b0;
            count_nxt   = '0;
          end
        end
      end
      mufl_pkg::IN_TICK: begin
        if (waiting_r) begin
          elapsed_nxt = elapsed_inc;
          if (fire) begin
            push        = 1'b1;
            job.kind    = mufl_pkg::RES_TIMEOUT;
            waiting_nxt = 1'b0;
            count_nxt   = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= mufl_pkg::DEV_ADDR_RST;
      timeout_r  <= mufl_pkg::TIMEOUT_RST;
      waiting_r  <= 1'b0;
      count_r    <= '0;
      elapsed_r  <= '0;
      crc_r      <= mufl_pkg::CRC_INIT;
      sent_cmd_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mufl_pkg::CFG_DEV_ADDR) begin
          dev_addr_r <= cfg_data[7:0];
        end else if (cfg_index == mufl_pkg::CFG_TIMEOUT) begin
          timeout_r <= cfg_data;
        end
      end
      if (accept) begin
        waiting_r  <= waiting_nxt;
        count_r    <= count_nxt;
        elapsed_r  <= elapsed_nxt;
        crc_r      <= crc_nxt;
        sent_cmd_r <= sent_cmd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      reply_store_r[count_r] <= in_rx_byte;
    end
  end

endmodule

/* src/mufl_queue.sv */
`timescale 1ns / 1ps
module mufl_queue #(
  parameter int DEPTH = mufl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  mufl_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mufl_pkg::job_t pop_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  mufl_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* src/mufl_back.sv */
`timescale 1ns / 1ps
module mufl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  mufl_pkg::job_t     job,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_kind,
  output logic [7:0]         out_tx_byte,
  output logic               out_tx_last,
  output logic               out_reply_crc_ok,
  output logic               out_reply_match,
  output logic signed [15:0] out_feedback_one,
  output logic signed [15:0] out_feedback_two,
  output logic [7:0]         out_temperature,
  output logic [7:0]         out_fault_code
);

  mufl_pkg::job_t cur_r;
  logic           cur_valid_r;
  logic [3:0]     idx_r;
  logic [7:0]     crc_r;
  logic [7:0]     frame_byte;
  logic           load_out;
  logic           beat;
  logic           last_beat;
  logic           is_tx;
  logic           is_reply;

  logic               out_valid_r;
  logic [1:0]         kind_r;
  logic [7:0]         tx_byte_r;
  logic               tx_last_r;
  logic               crc_ok_r;
  logic               match_r;
  logic signed [15:0] fb_one_r;
  logic signed [15:0] fb_two_r;
  logic [7:0]         temp_r;
  logic [7:0]         fault_r;

  assign is_tx     = (cur_r.kind == mufl_pkg::RES_TX);
  assign is_reply  = (cur_r.kind == mufl_pkg::RES_REPLY);
  assign load_out  = !out_valid_r || out_ready;
  assign beat      = cur_valid_r && load_out;
  assign last_beat = beat && (!is_tx || (idx_r == mufl_pkg::FRAME_CRC_IDX));
  assign job_ready = !cur_valid_r || last_beat;

  always_comb begin
    unique case (idx_r)
      4'd0:    frame_byte = cur_r.data[63:56];
      4'd1:    frame_byte = cur_r.data[55:48];
      4'd2:    frame_byte = cur_r.data[47:40];
      4'd3:    frame_byte = cur_r.data[39:32];
      4'd4:    frame_byte = cur_r.data[31:24];
      4'd5:    frame_byte = cur_r.data[23:16];
      4'd6:    frame_byte = cur_r.data[15:8];
      4'd7:    frame_byte = cur_r.data[7:0];
      4'd9:    frame_byte = crc_r;
      default: frame_byte = mufl_pkg::FRAME_PAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      crc_r       <= mufl_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        cur_valid_r <= 1'b1;
        idx_r       <= '0;
        crc_r       <= mufl_pkg::CRC_INIT;
      end else if (last_beat) begin
        cur_valid_r <= 1'b0;
      end else if (beat) begin
        idx_r <= idx_r + 4'd1;
        crc_r <= mufl_pkg::crc_feed(crc_r, frame_byte);
      end
      if (load_out) begin
        out_valid_r <= beat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      cur_r <= job;
    end
    if (beat) begin
      kind_r    <= cur_r.kind;
      tx_byte_r <= is_tx ? frame_byte : 8'd0;
      tx_last_r <= is_tx && (idx_r == mufl_pkg::FRAME_CRC_IDX);
      crc_ok_r  <= is_reply && cur_r.data[49];
      match_r   <= is_reply && cur_r.data[48];
      fb_one_r  <= is_reply ? cur_r.data[47:32] : 16'sd0;
      fb_two_r  <= is_reply ? cur_r.data[31:16] : 16'sd0;
      temp_r    <= is_reply ? cur_r.data[15:8] : 8'd0;
      fault_r   <= is_reply ? cur_r.data[7:0] : 8'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_tx_byte      = tx_byte_r;
  assign out_tx_last      = tx_last_r;
  assign out_reply_crc_ok = crc_ok_r;
  assign out_reply_match  = match_r;
  assign out_feedback_one = fb_one_r;
  assign out_feedback_two = fb_two_r;
  assign out_temperature  = temp_r;
  assign out_fault_code   = fault_r;

endmodule

/* src/motor_uart_frame_link.sv */
`timescale 1ns / 1ps
// Command and reply link for a serial motor. Each input transfer is a send, a
// received byte or a millisecond tick. A send produces ten transmit transfers on
// the output channel: the frame bytes in order, the last one the CRC-8 byte with
// out_tx_last set. A completed reply or a timeout produces one output transfer.
// Received bytes and ticks are taken one per cycle while in_ready is high and
// update the collector at once; the first output transfer of any item passes the
// job queue, current-job and output registers when the output is free. Sends back
// to back fill the four-entry job queue, then enter as the frame serializer ends
// each frame; other items go at one per cycle while the output is free. When the
// receiver stalls, the output register holds, the queue fills and in_ready drops
// only while the queue is full. The configuration channel is always ready and
// writes the device address (index 0) or reply_timeout_ms (index 1). A synchronous
// reset restores device address 1 and a 200 tick timeout, disarms the collector
// and empties the queue; it needs no clearing pass.
module motor_uart_frame_link #(
  parameter int TIMER_WIDTH = mufl_pkg::TIMER_WIDTH_DEF,
  parameter int QUEUE_DEPTH = mufl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mufl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mufl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_kind,
  input  logic [7:0]                      in_command_code,
  input  logic signed [15:0]              in_speed_value,
  input  logic [7:0]                      in_feedback_select_a,
  input  logic [7:0]                      in_feedback_select_b,
  input  logic [7:0]                      in_accel_time,
  input  logic [7:0]                      in_brake_code,
  input  logic                            in_expect_reply,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_result_kind,
  output logic [7:0]                      out_tx_byte,
  output logic                            out_tx_last,
  output logic                            out_reply_crc_ok,
  output logic                            out_reply_match,
  output logic signed [15:0]              out_feedback_one,
  output logic signed [15:0]              out_feedback_two,
  output logic [7:0]                      out_temperature,
  output logic [7:0]                      out_fault_code
);

  logic           fq_valid, fq_ready;
  mufl_pkg::job_t fq_job;
  logic           qb_valid, qb_ready;
  mufl_pkg::job_t qb_job;

  mufl_front #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_command_code     (in_command_code),
    .in_speed_value      (in_speed_value),
    .in_feedback_select_a(in_feedback_select_a),
    .in_feedback_select_b(in_feedback_select_b),
    .in_accel_time       (in_accel_time),
    .in_brake_code       (in_brake_code),
    .in_expect_reply     (in_expect_reply),
    .in_rx_byte          (in_rx_byte),
    .job_valid           (fq_valid),
    .job_ready           (fq_ready),
    .job                 (fq_job)
  );

  mufl_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_job  (fq_job),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_job   (qb_job)
  );

  mufl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (qb_valid),
    .job_ready       (qb_ready),
    .job             (qb_job),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_tx_byte     (out_tx_byte),
    .out_tx_last     (out_tx_last),
    .out_reply_crc_ok(out_reply_crc_ok),
    .out_reply_match (out_reply_match),
    .out_feedback_one(out_feedback_one),
    .out_feedback_two(out_feedback_two),
    .out_temperature (out_temperature),
    .out_fault_code  (out_fault_code)
  );

endmodule
